@@ design/vnp_pkg.sv @@
// Shared types, constants, constant dividers and palette tables for the noise palette pixel
`default_nettype none
package vnp_pkg;

  // Register codes
  localparam logic [2:0] REG_PALETTE = 3'd0;
  localparam logic [2:0] REG_SCALE   = 3'd1;
  localparam logic [2:0] REG_DRIFT_X = 3'd2;
  localparam logic [2:0] REG_DRIFT_Y = 3'd3;
  localparam logic [2:0] REG_SALT    = 3'd4;
  localparam logic [2:0] REG_SPEED   = 3'd5;

  localparam logic [2:0] PAL_LAST = 3'd4;

  // Hash and seed multipliers
  localparam logic [31:0] SEED_MULT = 32'd2654435761;
  localparam logic [31:0] CX_MULT   = 32'd374761393;
  localparam logic [31:0] CY_MULT   = 32'd668265263;
  localparam logic [31:0] MIX_A     = 32'h7feb352d;
  localparam logic [31:0] MIX_B     = 32'h846ca68b;

  // Reciprocals, ceil(2^k / d), exact over the stated input range
  localparam logic [27:0] DIV100_M  = 28'd171798692;  // k = 34, x < 2^27
  localparam logic [26:0] DIV1000_M = 27'd68719477;   // k = 36, x < 2^26
  localparam logic [16:0] DIV255_M  = 17'd65794;      // k = 24, x < 2^16
  localparam logic [24:0] DIV65025_M = 25'd16909061;  // k = 40, x < 2^24

  typedef struct packed {
    logic [2:0]  palette_select;
    logic [15:0] coord_scale;
    logic [15:0] drift_x_rate;
    logic [15:0] drift_y_rate;
    logic [31:0] pattern_salt;
    logic [7:0]  speed_percent;
  } cfg_t;

  function automatic logic [19:0] div100_q(input logic [26:0] x);
    logic [54:0] p;
    p = {28'd0, x} * {27'd0, DIV100_M};
    return p[53:34];
  endfunction

  function automatic logic [15:0] div1000_q(input logic [25:0] x);
    logic [52:0] p;
    p = {27'd0, x} * {26'd0, DIV1000_M};
    return p[51:36];
  endfunction

  function automatic logic [7:0] div255_q(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * {16'd0, DIV255_M};
    return p[31:24];
  endfunction

  function automatic logic [7:0] smooth_q(input logic [23:0] x);
    logic [48:0] p;
    p = {25'd0, x} * {24'd0, DIV65025_M};
    return p[47:40];
  endfunction

  // Gradient palettes, RGB packed red high
  localparam logic [23:0] PAL_ROM [5][16] = '{
    '{24'hFF0000, 24'hFF4000, 24'hFF8000, 24'hFFC000,
      24'hFFFF00, 24'h80FF00, 24'h00FF00, 24'h00FF80,
      24'h00FFFF, 24'h0080FF, 24'h0000FF, 24'h8000FF,
      24'hFF00FF, 24'hFF0080, 24'hFF0040, 24'hFF0000},
    '{24'h000020, 24'h000040, 24'h001060, 24'h002080,
      24'h1040A0, 24'h2060C0, 24'h4080E0, 24'h60A0FF,
      24'h80C0FF, 24'hA0E0FF, 24'hC0F0FF, 24'hE0F8FF,
      24'hFFFFFF, 24'hE0F8FF, 24'hA0E0FF, 24'h60A0FF},
    '{24'h000000, 24'h200000, 24'h400000, 24'h600000,
      24'h801000, 24'hA02000, 24'hC03000, 24'hE04000,
      24'hFF6000, 24'hFF8000, 24'hFFA000, 24'hFFC000,
      24'hFFE000, 24'hFFFF20, 24'hFFFF80, 24'hFFFFFF},
    '{24'h000800, 24'h001000, 24'h002000, 24'h003000,
      24'h004000, 24'h005000, 24'h006000, 24'h107000,
      24'h208000, 24'h309000, 24'h40A010, 24'h50B020,
      24'h60C030, 24'h70D040, 24'h80E050, 24'hA0FF80},
    '{24'h000000, 24'h100020, 24'h200040, 24'h400060,
      24'h600080, 24'h8000A0, 24'hA000C0, 24'hC000E0,
      24'hE000FF, 24'hFF00E0, 24'hFF00C0, 24'hFF00A0,
      24'hFF0080, 24'hFF2060, 24'hFF4040, 24'hFF6020}
  };

endpackage
`default_nettype wire

@@ design/vnp_coord.sv @@
// Time scaling, drift offsets, seed and noise coordinates (eight stages)
`default_nettype none
module vnp_coord (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [31:0]   frame_time,
  input  wire logic [5:0]    pixel_col,
  input  wire logic [3:0]    pixel_row,
  input  wire vnp_pkg::cfg_t cfg,
  output logic               out_vld,
  output logic [15:0]        nx,
  output logic [15:0]        ny,
  output logic [31:0]        seed
);

  logic [7:0]  vld;

  logic [39:0] prod1;
  logic [5:0]  col1, col2, col3, col4;
  logic [3:0]  row1, row2, row3, row4;
  logic [13:0] qh2, qh3, qh4;
  logic [19:0] ph2;
  logic [19:0] pl2, pl3;
  logic [6:0]  rh3;
  logic [19:0] ql4;
  logic [31:0] mx5, my5;
  logic [31:0] seed5, seed6, seed7;
  logic [15:0] px5, px6, px7, py5, py6, py7;
  logic [6:0]  q1x6, q1y6;
  logic [15:0] xh6, yh6, xl6, yl6, xl7, yl7;
  logic [9:0]  r1x7, r1y7;

  logic [19:0] qh_full;
  logic [19:0] rem_h;
  logic [31:0] t;
  logic [15:0] q1x_full, q1y_full;
  logic [15:0] rem_x, rem_y;

  always_comb begin
    qh_full  = vnp_pkg::div100_q({7'd0, prod1[39:20]});
    rem_h    = ph2 - ({6'd0, qh2} * 20'd100);
    t        = {qh4[11:0], ql4};
    q1x_full = vnp_pkg::div1000_q({10'd0, mx5[31:16]});
    q1y_full = vnp_pkg::div1000_q({10'd0, my5[31:16]});
    rem_x    = xh6 - ({9'd0, q1x6} * 16'd1000);
    rem_y    = yh6 - ({9'd0, q1y6} * 16'd1000);
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:0], in_vld};
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // scaled time product
      prod1 <= {8'd0, frame_time} * {32'd0, cfg.speed_percent};
      col1  <= pixel_col;
      row1  <= pixel_row;
      // divide by 100, high part
      qh2   <= qh_full[13:0];
      ph2   <= prod1[39:20];
      pl2   <= prod1[19:0];
      col2  <= col1;
      row2  <= row1;
      // remainder of high part
      rh3   <= rem_h[6:0];
      qh3   <= qh2;
      pl3   <= pl2;
      col3  <= col2;
      row3  <= row2;
      // divide by 100, low part
      ql4   <= vnp_pkg::div100_q({rh3, pl3});
      qh4   <= qh3;
      col4  <= col3;
      row4  <= row3;
      // drift, seed and pixel products
      mx5   <= t * {16'd0, cfg.drift_x_rate};
      my5   <= t * {16'd0, cfg.drift_y_rate};
      seed5 <= cfg.pattern_salt ^ (t * vnp_pkg::SEED_MULT);
      px5   <= {10'd0, col4} * cfg.coord_scale;
      py5   <= {12'd0, row4} * cfg.coord_scale;
      // divide by 1000, high part
      q1x6  <= q1x_full[6:0];
      q1y6  <= q1y_full[6:0];
      xh6   <= mx5[31:16];
      yh6   <= my5[31:16];
      xl6   <= mx5[15:0];
      yl6   <= my5[15:0];
      seed6 <= seed5;
      px6   <= px5;
      py6   <= py5;
      // remainder of high part
      r1x7  <= rem_x[9:0];
      r1y7  <= rem_y[9:0];
      xl7   <= xl6;
      yl7   <= yl6;
      seed7 <= seed6;
      px7   <= px6;
      py7   <= py6;
      // low 16 bits of the quotient come from the low part only
      nx    <= px7 + vnp_pkg::div1000_q({r1x7, xl7});
      ny    <= py7 + vnp_pkg::div1000_q({r1y7, yl7});
      seed  <= seed7;
    end
  end

  assign out_vld = vld[7];

endmodule
`default_nettype wire

@@ design/vnp_hash.sv @@
// Corner hashes and smoothstep fractions (three stages)
`default_nettype none
module vnp_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire logic [15:0] nx,
  input  wire logic [15:0] ny,
  input  wire logic [31:0] seed,
  output logic             out_vld,
  output logic [3:0][7:0]  corners,
  output logic [7:0]       u,
  output logic [7:0]       v
);

  logic [2:0]  vld;

  logic [31:0] xa9, xb9, ya9, yb9, seed9;
  logic [15:0] ffx9, ffy9;
  logic [9:0]  wx9, wy9;
  logic [3:0][31:0] g10, h11;
  logic [23:0] sux10, svy10;

  logic [3:0][31:0] hin;
  logic [8:0] xi1, yi1;

  always_comb begin
    xi1 = {1'b0, nx[15:8]} + 9'd1;
    yi1 = {1'b0, ny[15:8]} + 9'd1;
    hin[0] = seed9 ^ xa9 ^ ya9;
    hin[1] = seed9 ^ xb9 ^ ya9;
    hin[2] = seed9 ^ xa9 ^ yb9;
    hin[3] = seed9 ^ xb9 ^ yb9;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // cell products and fade terms
      xa9   <= {24'd0, nx[15:8]} * vnp_pkg::CX_MULT;
      xb9   <= {23'd0, xi1} * vnp_pkg::CX_MULT;
      ya9   <= {24'd0, ny[15:8]} * vnp_pkg::CY_MULT;
      yb9   <= {23'd0, yi1} * vnp_pkg::CY_MULT;
      seed9 <= seed;
      ffx9  <= {8'd0, nx[7:0]} * {8'd0, nx[7:0]};
      ffy9  <= {8'd0, ny[7:0]} * {8'd0, ny[7:0]};
      wx9   <= 10'd765 - {1'b0, nx[7:0], 1'b0};
      wy9   <= 10'd765 - {1'b0, ny[7:0], 1'b0};
      // first mix round, fade product
      for (int i = 0; i < 4; i++) begin
        g10[i] <= (hin[i] ^ (hin[i] >> 16)) * vnp_pkg::MIX_A;
      end
      sux10 <= {8'd0, ffx9} * {14'd0, wx9};
      svy10 <= {8'd0, ffy9} * {14'd0, wy9};
      // second mix round, fade divide
      for (int i = 0; i < 4; i++) begin
        h11[i] <= (g10[i] ^ (g10[i] >> 15)) * vnp_pkg::MIX_B;
      end
      u <= vnp_pkg::smooth_q(sux10);
      v <= vnp_pkg::smooth_q(svy10);
    end
  end

  // final xor-shift leaves the top byte untouched
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      corners[i] = h11[i][31:24];
    end
  end

  assign out_vld = vld[2];

endmodule
`default_nettype wire

@@ design/vnp_blend.sv @@
// Bilinear noise blend and palette lookup (seven stages)
`default_nettype none
module vnp_blend (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic       in_vld,
  input  wire logic [3:0][7:0] corners,
  input  wire logic [7:0] u,
  input  wire logic [7:0] v,
  input  wire logic [2:0] palette_select,
  output logic            out_vld,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue
);

  logic [6:0]  vld;

  // row blends
  logic [1:0][7:0]  ra1, ra2;
  logic [1:0]       rs1, rs2;
  logic [1:0][15:0] rp1;
  logic [1:0][7:0]  rq2;
  logic [7:0]       v1, v2;
  // column blend
  logic [7:0]  ca3, ca4;
  logic        cs3, cs4;
  logic [15:0] cp3;
  logic [7:0]  cq4;
  // palette blend
  logic [2:0][7:0]  pa5, pa6;
  logic [2:0]       ps5, ps6;
  logic [2:0][15:0] pp5;
  logic [2:0][7:0]  pq6;

  logic [1:0][7:0] rd, rlo, rhi;
  logic [1:0][7:0] r2;
  logic [7:0] cd, nv, frac;
  logic [3:0] seg, nxt;
  logic [2:0] pidx;
  logic [23:0] lo, hi;
  logic [2:0][7:0] pla, plb, pd;
  logic [2:0] pneg;

  always_comb begin
    // first blend: corners along x
    for (int i = 0; i < 2; i++) begin
      rlo[i] = corners[2*i];
      rhi[i] = corners[2*i+1];
      rd[i]  = (rhi[i] >= rlo[i]) ? rhi[i] - rlo[i] : rlo[i] - rhi[i];
      r2[i]  = rs2[i] ? ra2[i] - rq2[i] : ra2[i] + rq2[i];
    end
    cd = (r2[1] >= r2[0]) ? r2[1] - r2[0] : r2[0] - r2[1];
    // noise value and palette point
    nv   = cs4 ? ca4 - cq4 : ca4 + cq4;
    seg  = nv[7:4];
    nxt  = seg + 4'd1;
    frac = {4'd0, nv[3:0]} * 8'd17;
    pidx = (palette_select > vnp_pkg::PAL_LAST) ? vnp_pkg::PAL_LAST : palette_select;
    lo   = vnp_pkg::PAL_ROM[pidx][seg];
    hi   = vnp_pkg::PAL_ROM[pidx][nxt];
    for (int c = 0; c < 3; c++) begin
      pla[c]  = lo[23-8*c -: 8];
      plb[c]  = hi[23-8*c -: 8];
      pneg[c] = plb[c] < pla[c];
      pd[c]   = pneg[c] ? pla[c] - plb[c] : plb[c] - pla[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // row difference products
      for (int i = 0; i < 2; i++) begin
        ra1[i] <= rlo[i];
        rs1[i] <= rhi[i] < rlo[i];
        rp1[i] <= {8'd0, rd[i]} * {8'd0, u};
        ra2[i] <= ra1[i];
        rs2[i] <= rs1[i];
        rq2[i] <= vnp_pkg::div255_q(rp1[i]);
      end
      v1  <= v;
      v2  <= v1;
      // column blend
      ca3 <= r2[0];
      cs3 <= r2[1] < r2[0];
      cp3 <= {8'd0, cd} * {8'd0, v2};
      ca4 <= ca3;
      cs4 <= cs3;
      cq4 <= vnp_pkg::div255_q(cp3);
      // palette channels
      for (int c = 0; c < 3; c++) begin
        pa5[c] <= pla[c];
        ps5[c] <= pneg[c];
        pp5[c] <= {8'd0, pd[c]} * {8'd0, frac};
        pa6[c] <= pa5[c];
        ps6[c] <= ps5[c];
        pq6[c] <= vnp_pkg::div255_q(pp5[c]);
      end
      red   <= ps6[0] ? pa6[0] - pq6[0] : pa6[0] + pq6[0];
      green <= ps6[1] ? pa6[1] - pq6[1] : pa6[1] + pq6[1];
      blue  <= ps6[2] ? pa6[2] - pq6[2] : pa6[2] + pq6[2];
    end
  end

  assign out_vld = vld[6];

endmodule
`default_nettype wire

@@ design/value_noise_palette_pixel.sv @@
// Top level: animated value-noise pixel colour with gradient palettes
//
// Pixel channel: frame_time, pixel_col and pixel_row with pixel_valid and
// pixel_stall; a transfer happens on a clock edge with valid high, stall low.
// Colour channel: red, green and blue with colour_valid and colour_stall.
// Registers are written over the APB port at byte addresses 4*i. The user
// must write only while the pipeline holds no pixel; the block itself has no
// check for it. The pipeline has 18 register stages, and one pixel can be
// taken every cycle while no finished colour is stalled.
// All stages advance together; when the colour output holds a result and the
// receiver stalls, the whole pipeline holds and pixel_stall rises in the
// same cycle, so nothing is lost or repeated.
// Reset clears every valid bit and loads the register defaults.
`default_nettype none
module value_noise_palette_pixel (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        pixel_valid,
  output logic             pixel_stall,
  input  wire logic [31:0] frame_time,
  input  wire logic [5:0]  pixel_col,
  input  wire logic [3:0]  pixel_row,
  output logic             colour_valid,
  input  wire logic        colour_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  vnp_pkg::cfg_t cfg;

  logic        en;
  logic        coord_vld, hash_vld;
  logic [15:0] nx, ny;
  logic [31:0] seed;
  logic [3:0][7:0] corners;
  logic [7:0]  u, v;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.palette_select <= 3'd0;
      cfg.coord_scale    <= 16'd18;
      cfg.drift_x_rate   <= 16'd22;
      cfg.drift_y_rate   <= 16'd11;
      cfg.pattern_salt   <= 32'hA1B2C3D4;
      cfg.speed_percent  <= 8'd100;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        vnp_pkg::REG_PALETTE: cfg.palette_select <= pwdata[2:0];
        vnp_pkg::REG_SCALE:   cfg.coord_scale    <= pwdata[15:0];
        vnp_pkg::REG_DRIFT_X: cfg.drift_x_rate   <= pwdata[15:0];
        vnp_pkg::REG_DRIFT_Y: cfg.drift_y_rate   <= pwdata[15:0];
        vnp_pkg::REG_SALT:    cfg.pattern_salt   <= pwdata;
        vnp_pkg::REG_SPEED:   cfg.speed_percent  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      vnp_pkg::REG_PALETTE: prdata = {29'd0, cfg.palette_select};
      vnp_pkg::REG_SCALE:   prdata = {16'd0, cfg.coord_scale};
      vnp_pkg::REG_DRIFT_X: prdata = {16'd0, cfg.drift_x_rate};
      vnp_pkg::REG_DRIFT_Y: prdata = {16'd0, cfg.drift_y_rate};
      vnp_pkg::REG_SALT:    prdata = cfg.pattern_salt;
      vnp_pkg::REG_SPEED:   prdata = {24'd0, cfg.speed_percent};
      default:              prdata = 32'd0;
    endcase
  end

  // Global advance: hold only when a finished colour is stalled
  assign en          = !(colour_valid && colour_stall);
  assign pixel_stall = !en;

  vnp_coord u_coord (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_vld     (pixel_valid),
    .frame_time (frame_time),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .cfg        (cfg),
    .out_vld    (coord_vld),
    .nx         (nx),
    .ny         (ny),
    .seed       (seed)
  );

  vnp_hash u_hash (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (coord_vld),
    .nx      (nx),
    .ny      (ny),
    .seed    (seed),
    .out_vld (hash_vld),
    .corners (corners),
    .u       (u),
    .v       (v)
  );

  vnp_blend u_blend (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_vld         (hash_vld),
    .corners        (corners),
    .u              (u),
    .v              (v),
    .palette_select (cfg.palette_select),
    .out_vld        (colour_valid),
    .red            (red),
    .green          (green),
    .blue           (blue)
  );

endmodule
`default_nettype wire
